// File: sv/tte_pkg.sv
package tte_pkg;

    localparam int BYTE_W    = 8;
    localparam int STOP_W    = 12;
    localparam int REP_W     = 12;
    localparam int COLOUT_W  = 12;
    localparam int COUNT_W   = 3;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 12;

    localparam logic [BYTE_W-1:0] CH_TAB   = 8'd9;
    localparam logic [BYTE_W-1:0] CH_BS    = 8'd8;
    localparam logic [BYTE_W-1:0] CH_NL    = 8'd10;
    localparam logic [BYTE_W-1:0] CH_SPACE = 8'd32;

    localparam logic [STOP_W-1:0]  DEFAULT_STOP  = 12'd4;
    localparam logic [COUNT_W-1:0] DEFAULT_COUNT = 3'd1;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_STOP_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STOP_FIRST = 3'd1;

    // commands from the controller to the datapath
    typedef struct packed {
        logic accept;
        logic scan_step;
        logic div_start;
        logic div_step;
        logic div_end;
        logic finish;
    } tte_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic in_tab;
        logic scan_hit;
        logic scan_last;
        logic div_last;
        logic out_busy;
    } tte_sts_t;

endpackage

// File: sv/tte_ctrl.sv
module tte_ctrl
    import tte_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  tte_sts_t sts,
    output tte_cmd_t cmd
);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_SCAN    = 3'd1;
    localparam logic [2:0] S_DIVINIT = 3'd2;
    localparam logic [2:0] S_DIV     = 3'd3;
    localparam logic [2:0] S_REM     = 3'd4;
    localparam logic [2:0] S_DONE    = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = sts.in_tab ? S_SCAN : S_DONE;
                end
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (sts.scan_hit)
                begin
                    state_next = S_DONE;
                end
                else if (sts.scan_last)
                begin
                    state_next = S_DIVINIT;
                end
            end
            S_DIVINIT:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last)
                begin
                    state_next = S_REM;
                end
            end
            S_REM:
            begin
                cmd.div_end = 1'b1;
                state_next  = S_DONE;
            end
            S_DONE:
            begin
                if (!sts.out_busy)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// File: sv/tte_dp.sv
module tte_dp
    import tte_pkg::*;
#(
    parameter int MAX_STOPS   = 6,
    parameter int COLUMN_BITS = 12
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic [BYTE_W-1:0]     in_byte,
    input  tte_cmd_t              cmd,
    output tte_sts_t              sts,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [BYTE_W-1:0]     out_byte,
    output logic [REP_W-1:0]      repeat_count,
    output logic [COLOUT_W-1:0]   column_after
);

    localparam int W     = (COLUMN_BITS > STOP_W) ? COLUMN_BITS : STOP_W;
    localparam int IDX_W = (MAX_STOPS > 1) ? $clog2(MAX_STOPS) : 1;
    localparam int CNT_W = $clog2(W + 1);
    localparam logic [COLUMN_BITS-1:0] COL_MAX = '1;

    // configuration
    logic [COUNT_W-1:0] stop_count_reg;
    logic [STOP_W-1:0]  stops_reg [MAX_STOPS];

    // working registers
    logic [BYTE_W-1:0]      byte_reg;
    logic [COLUMN_BITS-1:0] col_reg;
    logic [IDX_W-1:0]       idx_reg;
    logic [STOP_W-1:0]      last_reg;
    logic [STOP_W-1:0]      prev_reg;
    logic [STOP_W-1:0]      period_reg;
    logic [STOP_W-1:0]      rem_reg;
    logic [W-1:0]           dvd_reg;
    logic [CNT_W-1:0]       cnt_reg;
    logic [REP_W-1:0]       dist_reg;

    // result register
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic [BYTE_W-1:0]      out_byte_reg;
    logic [REP_W-1:0]       rep_reg;
    logic [COLOUT_W-1:0]    colout_reg;

    logic [COUNT_W-1:0]     n_used;
    logic [IDX_W-1:0]       last_idx;
    logic [STOP_W-1:0]      stop_cur;
    logic [W-1:0]           col_w;
    logic [W-1:0]           stop_w;
    logic [W-1:0]           hit_diff;
    logic                   hit;
    logic [STOP_W:0]        div_trial;
    logic [STOP_W:0]        div_diff;
    logic [W:0]             tab_sum;
    logic [COLUMN_BITS-1:0] col_new;
    logic [W-1:0]           col_new_w;
    logic [CFG_IDX_W-1:0]   wr_off;

    always_comb
    begin
        if (stop_count_reg == '0)
        begin
            n_used = COUNT_W'(1);
        end
        else if (stop_count_reg > COUNT_W'(MAX_STOPS))
        begin
            n_used = COUNT_W'(MAX_STOPS);
        end
        else
        begin
            n_used = stop_count_reg;
        end
    end

    assign last_idx = IDX_W'(n_used - COUNT_W'(1));
    assign stop_cur = stops_reg[idx_reg];
    assign col_w    = W'(col_reg);
    assign stop_w   = W'(stop_cur);
    assign hit      = stop_w > col_w;
    assign hit_diff = stop_w - col_w;
    assign div_trial = {rem_reg, dvd_reg[W-1]};
    assign div_diff  = div_trial - {1'b0, period_reg};
    assign tab_sum   = {1'b0, col_w} + (W+1)'(dist_reg);
    assign wr_off    = cfg_index - REG_STOP_FIRST;

    assign sts.in_tab    = (in_byte == CH_TAB);
    assign sts.scan_hit  = hit;
    assign sts.scan_last = (idx_reg == last_idx);
    assign sts.div_last  = (cnt_reg == CNT_W'(1));
    assign sts.out_busy  = out_valid_reg && !out_ready;

    // column after the held byte
    always_comb
    begin
        case (byte_reg)
            CH_TAB:
            begin
                if (tab_sum > (W+1)'(COL_MAX))
                begin
                    col_new = COL_MAX;
                end
                else
                begin
                    col_new = tab_sum[COLUMN_BITS-1:0];
                end
            end
            CH_BS:
            begin
                col_new = (col_reg != '0) ? col_reg - COLUMN_BITS'(1) : col_reg;
            end
            CH_NL:
            begin
                col_new = '0;
            end
            default:
            begin
                col_new = (col_reg != COL_MAX) ? col_reg + COLUMN_BITS'(1) : col_reg;
            end
        endcase
    end

    assign col_new_w = W'(col_new);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stop_count_reg <= DEFAULT_COUNT;
            for (int i = 0; i < MAX_STOPS; i++)
            begin
                stops_reg[i] <= (i == 0) ? DEFAULT_STOP : '0;
            end
        end
        else if (cfg_write)
        begin
            if (cfg_index == REG_STOP_COUNT)
            begin
                stop_count_reg <= cfg_data[COUNT_W-1:0];
            end
            else if (wr_off < CFG_IDX_W'(MAX_STOPS))
            begin
                stops_reg[IDX_W'(wr_off)] <= cfg_data[STOP_W-1:0];
            end
        end
    end

    assign out_valid_next = cmd.finish ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (cmd.finish)
            begin
                col_reg <= col_new;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            byte_reg <= in_byte;
            idx_reg  <= '0;
            last_reg <= '0;
            dist_reg <= REP_W'(1);
        end
        if (cmd.scan_step)
        begin
            prev_reg <= last_reg;
            last_reg <= stop_cur;
            if (hit)
            begin
                dist_reg <= hit_diff[REP_W-1:0];
            end
            else if (idx_reg != last_idx)
            begin
                idx_reg <= idx_reg + IDX_W'(1);
            end
        end
        if (cmd.div_start)
        begin
            period_reg <= (last_reg > prev_reg) ? last_reg - prev_reg : STOP_W'(1);
            dvd_reg    <= col_w - W'(last_reg);
            rem_reg    <= '0;
            cnt_reg    <= CNT_W'(W);
        end
        if (cmd.div_step)
        begin
            if (div_trial >= {1'b0, period_reg})
            begin
                rem_reg <= div_diff[STOP_W-1:0];
            end
            else
            begin
                rem_reg <= div_trial[STOP_W-1:0];
            end
            dvd_reg <= {dvd_reg[W-2:0], 1'b0};
            cnt_reg <= cnt_reg - CNT_W'(1);
        end
        if (cmd.div_end)
        begin
            dist_reg <= period_reg - rem_reg;
        end
        if (cmd.finish)
        begin
            out_byte_reg <= (byte_reg == CH_TAB) ? CH_SPACE : byte_reg;
            rep_reg      <= dist_reg;
            colout_reg   <= col_new_w[COLOUT_W-1:0];
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_byte     = out_byte_reg;
    assign repeat_count = rep_reg;
    assign column_after = colout_reg;

endmodule

// File: sv/tab_to_space_expander.sv
// A tab scans the explicit stops in order; one past the last stop it runs the divider over
//   W bits, W the larger of COLUMN_BITS and 12 (one remainder bit a cycle in the divider).
// Any other byte goes straight to the result. A result waits while the last one is untaken.
// One item at a time: no new byte is taken until the last one is in the result register.
// Reset (rst_n, asynchronous, active low): column zero, one stop at column four, result
//   register empty.
module tab_to_space_expander
    import tte_pkg::*;
#(
    parameter int MAX_STOPS   = 6,
    parameter int COLUMN_BITS = 12
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [BYTE_W-1:0]     in_byte,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [BYTE_W-1:0]     out_byte,
    output logic [REP_W-1:0]      repeat_count,
    output logic [COLOUT_W-1:0]   column_after
);

    tte_cmd_t cmd;
    tte_sts_t sts;

    // Sequence each transaction: latch the byte; for a tab, scan the explicit stops one per cycle
    // and fall back to the repeating rule through the remainder divider; then load the result.
    tte_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Hold the stops, the column and the result register; the result register lets the
    // next input transaction in while a finished result still waits downstream.
    tte_dp #(
        .MAX_STOPS   (MAX_STOPS),
        .COLUMN_BITS (COLUMN_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_byte      (in_byte),
        .cmd          (cmd),
        .sts          (sts),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_byte     (out_byte),
        .repeat_count (repeat_count),
        .column_after (column_after)
    );

`ifndef SYNTHESIS
    // a result never carries an empty run
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> repeat_count != '0)
        else $error("zero repeat count");

    // only a space can carry a run longer than one
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_byte != CH_SPACE |-> repeat_count == REP_W'(1))
        else $error("repeat above one on a byte other than space");

    // a newline always leaves the column at zero
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_byte == CH_NL |-> column_after == '0)
        else $error("newline did not reset the column");

    // one transaction in flight: input closes right after an acceptance
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second input taken while busy");
`endif

endmodule

// File: sim/tb_tab_to_space_expander.sv
module tb_tab_to_space_expander;
    timeunit 1ns;
    timeprecision 1ps;

    import tte_pkg::*;

    // Block configuration under test, kept at the defaults of the design
    localparam int MAX_STOPS   = 6;
    localparam int COLUMN_BITS = 12;
    localparam int COL_MAX     = (1 << COLUMN_BITS) - 1;
    localparam int REPEAT_MAX  = 4095;

    // Register indexes beyond the two that the package names
    localparam logic [CFG_IDX_W-1:0] REG_STOP_SECOND = REG_STOP_FIRST + 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STOP_THIRD  = REG_STOP_FIRST + 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STOP_FOURTH = REG_STOP_FIRST + 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_STOP_FIFTH  = REG_STOP_FIRST + 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_STOP_SIXTH  = REG_STOP_FIRST + 3'd5;

    localparam int RANDOM_PHASES    = 9;
    localparam int ITEMS_PER_PHASE  = 125;
    localparam int DRAIN_CYCLES     = 30;

    // One expanded character as it leaves the block
    typedef struct packed {
        logic [BYTE_W-1:0]   out_ch;
        logic [REP_W-1:0]    reps;
        logic [COLOUT_W-1:0] col_after;
    } expand_t;

    typedef enum logic [1:0] {
        ROW_WRITE,
        ROW_CHAR
    } row_kind_t;

    // One row of the directed table: a register write or a character, the latter
    // optionally with its expansion typed in by hand
    typedef struct {
        row_kind_t              kind;
        logic [CFG_IDX_W-1:0]   idx;
        logic [CFG_DATA_W-1:0]  data;
        logic [BYTE_W-1:0]      ch;
        bit                     pinned;
        expand_t                want;
    } row_t;

    logic                  clk          = 1'b0;
    logic                  rst_n        = 1'b0;
    logic                  cfg_write    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index    = '0;
    logic [CFG_DATA_W-1:0] cfg_data     = '0;
    logic                  in_valid     = 1'b0;
    logic                  in_ready;
    logic [BYTE_W-1:0]     in_byte      = '0;
    logic                  out_valid;
    logic                  out_ready    = 1'b0;
    logic [BYTE_W-1:0]     out_byte;
    logic [REP_W-1:0]      repeat_count;
    logic [COLOUT_W-1:0]   column_after;

    // Hand-typed expansion travelling alongside the character it belongs to
    bit      pin_on   = 1'b0;
    expand_t pin_want = '0;

    // Shadow of the tab stop registers and of the column, as the block should hold them
    int shadow_count    = DEFAULT_COUNT;
    int shadow_stops[6] = '{DEFAULT_STOP, 0, 0, 0, 0, 0};
    int track_col       = 0;

    expand_t expansions_due[$];
    row_t    directed_rows[$];

    int err_count  = 0;
    int result_no  = 0;
    int idle_rate  = 0;   // percent chance of an idle gap before each character and of a stall burst each cycle
    int stall_left = 0;

    tab_to_space_expander #(
        .MAX_STOPS   (MAX_STOPS),
        .COLUMN_BITS (COLUMN_BITS)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .in_byte      (in_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_byte     (out_byte),
        .repeat_count (repeat_count),
        .column_after (column_after)
    );

    // 8 ns clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Watchdog: far beyond the slowest legal run
    initial
    begin
        #4_000_000;
        $display("simulation failed");
        $finish;
    end

    // Expand one character against the shadow stops and advance the tracked column
    function automatic expand_t expand_byte(input logic [BYTE_W-1:0] ch);
        int      n;
        int      i;
        int      col;
        int      stop;
        int      last_s;
        int      prev_s;
        int      period;
        int      run_len;
        bit      found;
        expand_t r;
        col         = track_col;
        r.out_ch    = ch;
        r.reps      = REP_W'(1);
        if (ch == CH_TAB)
        begin
            // clamp the stop count into 1..MAX_STOPS
            n = shadow_count;
            if (n < 1)
                n = 1;
            if (n > MAX_STOPS)
                n = MAX_STOPS;
            // first explicit stop beyond the column, in register order
            found = 1'b0;
            stop  = 0;
            for (i = 0; i < n; i++)
            begin
                if (!found && shadow_stops[i] > col)
                begin
                    stop  = shadow_stops[i];
                    found = 1'b1;
                end
            end
            // otherwise repeat past the last stop; a non-positive period counts as one
            if (!found)
            begin
                last_s = shadow_stops[n-1];
                prev_s = (n > 1) ? shadow_stops[n-2] : 0;
                period = (last_s > prev_s) ? (last_s - prev_s) : 1;
                stop   = last_s + (1 + (col - last_s) / period) * period;
            end
            run_len = stop - col;
            if (run_len > REPEAT_MAX)
                run_len = REPEAT_MAX;
            r.out_ch = CH_SPACE;
            r.reps   = REP_W'(run_len);
            col      = col + run_len;
            if (col > COL_MAX)
                col = COL_MAX;
        end
        else if (ch == CH_BS)
        begin
            if (col > 0)
                col = col - 1;
        end
        else if (ch == CH_NL)
            col = 0;
        else if (col < COL_MAX)
            col = col + 1;
        track_col   = col;
        r.col_after = COLOUT_W'(col);
        return r;
    endfunction

    function automatic void add_write(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] data);
        row_t row;
        row        = '{kind: ROW_WRITE, default: '0};
        row.idx    = idx;
        row.data   = data;
        directed_rows.push_back(row);
    endfunction

    function automatic void add_char(input logic [BYTE_W-1:0] ch);
        row_t row;
        row        = '{kind: ROW_CHAR, default: '0};
        row.ch     = ch;
        directed_rows.push_back(row);
    endfunction

    function automatic void add_pinned(input logic [BYTE_W-1:0] ch,
                                       input logic [BYTE_W-1:0] o,
                                       input logic [REP_W-1:0] reps,
                                       input logic [COLOUT_W-1:0] col);
        row_t row;
        row        = '{kind: ROW_CHAR, default: '0};
        row.ch     = ch;
        row.pinned = 1'b1;
        row.want   = '{out_ch: o, reps: reps, col_after: col};
        directed_rows.push_back(row);
    endfunction

    task automatic report(input string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        err_count++;
    endtask

    // Write one register: hold the write enable for a single edge, then drop it
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    // Present one character and hold it until the input transaction completes
    task automatic send_char(input logic [BYTE_W-1:0] ch, input bit pinned,
                             input expand_t want);
        int gap;
        if (idle_rate != 0 && $urandom_range(0, 99) < idle_rate)
        begin
            gap = $urandom_range(1, 5);
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid <= 1'b1;
        in_byte  <= ch;
        pin_on   <= pinned;
        pin_want <= want;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // Drop valid and wait until every expansion has come back and the block is idle
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expansions_due.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    // Result side back-pressure: random stall bursts while idling is on
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left = stall_left - 1;
            out_ready <= 1'b0;
        end
        else if (idle_rate != 0 && $urandom_range(0, 99) < idle_rate)
        begin
            stall_left = $urandom_range(1, 5) - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    // Track register writes and input transactions, and check every result transaction
    // against the oldest expansion still due
    always @(posedge clk)
    begin : monitor
        expand_t want;
        if (rst_n)
        begin
            if (cfg_write)
            begin
                if (cfg_index == REG_STOP_COUNT)
                    shadow_count = int'(cfg_data[COUNT_W-1:0]);
                else if (cfg_index <= REG_STOP_SIXTH)
                    shadow_stops[cfg_index - REG_STOP_FIRST] = int'(cfg_data);
            end
            if (in_valid && in_ready)
            begin
                // advance the shadow column always; a hand-typed row takes precedence
                want = expand_byte(in_byte);
                expansions_due.push_back(pin_on ? pin_want : want);
            end
            if (out_valid && out_ready)
            begin
                if (expansions_due.size() == 0)
                    report($sformatf("result %0d arrived with nothing due: byte %0d",
                                     result_no, out_byte));
                else
                begin
                    want = expansions_due.pop_front();
                    if (out_byte !== want.out_ch)
                        report($sformatf("result %0d out_byte %0d, want %0d",
                                         result_no, out_byte, want.out_ch));
                    if (repeat_count !== want.reps)
                        report($sformatf("result %0d repeat_count %0d, want %0d",
                                         result_no, repeat_count, want.reps));
                    if (column_after !== want.col_after)
                        report($sformatf("result %0d column_after %0d, want %0d",
                                         result_no, column_after, want.col_after));
                end
                result_no++;
            end
        end
    end

    initial
    begin : stimulus
        int                    i;
        int                    j;
        int                    p;
        int                    r;
        int                    style;
        int                    nl_pct;
        int                    cnt;
        int                    acc;
        int                    stops[6];
        logic [BYTE_W-1:0]     ch;

        // Directed table. Reset stops: one stop at four, repeating every four.
        add_pinned(CH_TAB,   CH_SPACE, 12'd4, 12'd4);
        add_pinned(8'h41,    8'h41,    12'd1, 12'd5);
        add_pinned(CH_TAB,   CH_SPACE, 12'd3, 12'd8);
        add_pinned(CH_BS,    CH_BS,    12'd1, 12'd7);
        add_pinned(CH_NL,    CH_NL,    12'd1, 12'd0);
        // backspace at column zero leaves the column alone
        add_pinned(CH_BS,    CH_BS,    12'd1, 12'd0);
        add_pinned(8'hFF,    8'hFF,    12'd1, 12'd1);
        add_pinned(8'h00,    8'h00,    12'd1, 12'd2);
        add_pinned(CH_TAB,   CH_SPACE, 12'd2, 12'd4);
        // single stop at the column limit: full-width tabs and saturation
        add_write(REG_STOP_COUNT, 12'd1);
        add_write(REG_STOP_FIRST, 12'd4095);
        add_pinned(CH_NL,    CH_NL,    12'd1,    12'd0);
        add_pinned(CH_TAB,   CH_SPACE, 12'd4095, 12'd4095);
        add_pinned(CH_TAB,   CH_SPACE, 12'd4095, 12'd4095);
        add_pinned(8'h78,    8'h78,    12'd1,    12'd4095);
        add_pinned(CH_BS,    CH_BS,    12'd1,    12'd4094);
        add_pinned(CH_TAB,   CH_SPACE, 12'd1,    12'd4095);
        // stop count of zero behaves as one stop
        add_write(REG_STOP_COUNT, 12'd0);
        add_write(REG_STOP_FIRST, 12'd1);
        add_pinned(CH_NL,    CH_NL,    12'd1, 12'd0);
        add_pinned(CH_TAB,   CH_SPACE, 12'd1, 12'd1);
        add_pinned(CH_TAB,   CH_SPACE, 12'd1, 12'd2);
        // single stop at zero: period falls back to one
        add_write(REG_STOP_FIRST, 12'd0);
        add_char(CH_TAB);
        // count above the maximum, stops out of order and a zero period at the end
        add_write(REG_STOP_COUNT,  12'd7);
        add_write(REG_STOP_FIRST,  12'd3);
        add_write(REG_STOP_SECOND, 12'd10);
        add_write(REG_STOP_THIRD,  12'd2);
        add_write(REG_STOP_FOURTH, 12'd20);
        add_write(REG_STOP_FIFTH,  12'd30);
        add_write(REG_STOP_SIXTH,  12'd30);
        add_char(CH_NL);
        for (i = 0; i < 5; i++)
            add_char(CH_TAB);
        add_char(8'h7A);

        // Hold reset, then release it on a falling edge
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Walk the directed table; settle before every register write
        idle_rate = 20;
        for (i = 0; i < directed_rows.size(); i++)
        begin
            if (directed_rows[i].kind == ROW_WRITE)
            begin
                settle();
                write_reg(directed_rows[i].idx, directed_rows[i].data);
            end
            else
                send_char(directed_rows[i].ch, directed_rows[i].pinned,
                          directed_rows[i].want);
        end

        // Random phases, each with fresh stops; phase three and the last one run without idling
        for (p = 0; p < RANDOM_PHASES; p++)
        begin
            settle();
            cnt    = $urandom_range(0, 7);
            style  = p % 4;
            nl_pct = 8;
            case (style)
                0:
                begin
                    // tightly spaced increasing stops
                    acc = 0;
                    for (j = 0; j < 6; j++)
                    begin
                        acc      = acc + $urandom_range(1, 12);
                        stops[j] = acc;
                    end
                end
                1:
                begin
                    // anything the register width allows, ordered or not
                    for (j = 0; j < 6; j++)
                        stops[j] = $urandom_range(0, COL_MAX);
                end
                2:
                begin
                    // one wide stop, few newlines: drives the column to its limit
                    cnt    = 1;
                    nl_pct = 1;
                    for (j = 0; j < 6; j++)
                        stops[j] = $urandom_range(1, COL_MAX);
                end
                default:
                begin
                    // span the whole column range, ending on the limit
                    stops[0] = 1;
                    for (j = 1; j < 5; j++)
                        stops[j] = $urandom_range(stops[j-1] + 1, stops[j-1] + 800);
                    stops[5] = COL_MAX;
                end
            endcase
            write_reg(REG_STOP_COUNT, CFG_DATA_W'(cnt));
            for (j = 0; j < 6; j++)
                write_reg(CFG_IDX_W'(REG_STOP_FIRST + j), CFG_DATA_W'(stops[j]));

            if (p == RANDOM_PHASES - 1 || p == 3)
                idle_rate = 0;
            else
                idle_rate = $urandom_range(10, 40);

            for (i = 0; i < ITEMS_PER_PHASE; i++)
            begin
                r = $urandom_range(0, 99);
                if (r < 30)
                    ch = CH_TAB;
                else if (r < 40)
                    ch = CH_BS;
                else if (r < 40 + nl_pct)
                    ch = CH_NL;
                else if (r < 85)
                    ch = BYTE_W'($urandom_range(8'h20, 8'h7E));
                else
                    ch = BYTE_W'($urandom_range(0, 255));
                send_char(ch, 1'b0, '0);
            end
        end

        // Drain, then leave room for anything stray to show up
        settle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (err_count == 0 && expansions_due.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
